/* rtl/bcc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg
// shared types and constants for the button click classifier
// ----------------------------------------------------------------------------
package bcc_pkg;

	localparam int TimeW  = 32;
	localparam int CfgW   = 16;
	localparam int EventW = 2;
	localparam int AddrW  = 4;
	localparam int DataW  = 32;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_PRESSED  = 2'd1,
		PH_WAIT_DBL = 2'd2,
		PH_PRESSED2 = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_LONG_PRESS = 2'd1,
		REG_DOUBLE_GAP = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

	localparam logic [EventW-1:0] EV_NONE   = 2'd0;
	localparam logic [EventW-1:0] EV_SINGLE = 2'd1;
	localparam logic [EventW-1:0] EV_DOUBLE = 2'd2;

	localparam logic [CfgW-1:0] DEBOUNCE_RST   = 16'd20;
	localparam logic [CfgW-1:0] LONG_PRESS_RST = 16'd2000;
	localparam logic [CfgW-1:0] DOUBLE_GAP_RST = 16'd300;

	typedef struct packed {
		logic [CfgW-1:0] debounce_ms;
		logic [CfgW-1:0] long_press_ms;
		logic [CfgW-1:0] double_gap_ms;
	} cfg_t;

endpackage
`default_nettype wire

/* rtl/bcc_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_cfg
// apb register file holding the three timing registers
// ----------------------------------------------------------------------------
module bcc_cfg
	import bcc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [DataW-1:0] pwdata,
	output logic      [DataW-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
			cfg_q.long_press_ms <= LONG_PRESS_RST;
			cfg_q.double_gap_ms <= DOUBLE_GAP_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEBOUNCE:   cfg_q.debounce_ms   <= pwdata[CfgW-1:0];
				REG_LONG_PRESS: cfg_q.long_press_ms <= pwdata[CfgW-1:0];
				REG_DOUBLE_GAP: cfg_q.double_gap_ms <= pwdata[CfgW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_DEBOUNCE:   prdata[CfgW-1:0] = cfg_q.debounce_ms;
			REG_LONG_PRESS: prdata[CfgW-1:0] = cfg_q.long_press_ms;
			REG_DOUBLE_GAP: prdata[CfgW-1:0] = cfg_q.double_gap_ms;
			default:        prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/bcc_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_core
// debounce test and click phase machine, one sample per enabled cycle
// ----------------------------------------------------------------------------
module bcc_core
	import bcc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic [TimeW-1:0]  now_ms,
	input  wire logic              pressed_level,
	input  wire cfg_t              cfg,
	output logic      [EventW-1:0] click_event
);

	phase_t             phase_q, phase_d;
	logic [TimeW-1:0]   last_edge_q, release_q, press_start_q;
	logic               stable_q;

	logic [TimeW-1:0]   since_edge, since_press, since_release;
	logic               edge_ok, press_edge, release_edge;
	logic               held_long, released_now, gap_over;

	// all differences wrap mod 2^32
	assign since_edge    = now_ms - last_edge_q;
	assign since_press   = now_ms - press_start_q;
	assign since_release = now_ms - release_q;

	assign edge_ok      = (pressed_level != stable_q) &&
	                      (since_edge >= {{(TimeW-CfgW){1'b0}}, cfg.debounce_ms});
	assign press_edge   = edge_ok & pressed_level;
	assign release_edge = edge_ok & ~pressed_level;
	assign held_long    = since_press >= {{(TimeW-CfgW){1'b0}}, cfg.long_press_ms};
	assign released_now = release_edge && (phase_q == PH_PRESSED) && !held_long;
	// a release in this very sample sees a zero gap, so only an older release can time out
	assign gap_over     = (phase_q == PH_WAIT_DBL) && !press_edge &&
	                      (since_release > {{(TimeW-CfgW){1'b0}}, cfg.double_gap_ms});

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (press_edge) begin
			phase_d = (phase_q == PH_WAIT_DBL) ? PH_PRESSED2 : PH_PRESSED;
		end else if (release_edge) begin
			unique case (phase_q)
				PH_PRESSED:  phase_d = held_long ? PH_IDLE : PH_WAIT_DBL;
				PH_PRESSED2: phase_d = PH_IDLE;
				default:     phase_d = phase_q;
			endcase
		end
		if (gap_over) begin
			phase_d = PH_IDLE;
		end
	end

	// event
	always_comb begin
		click_event = EV_NONE;
		if (release_edge && phase_q == PH_PRESSED2) begin
			click_event = EV_DOUBLE;
		end
		if (gap_over) begin
			click_event = EV_SINGLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			last_edge_q   <= '0;
			release_q     <= '0;
			press_start_q <= '0;
			stable_q      <= 1'b0;
		end else if (en) begin
			phase_q <= phase_d;
			if (edge_ok) begin
				last_edge_q <= now_ms;
				stable_q    <= pressed_level;
			end
			if (press_edge && phase_q != PH_WAIT_DBL) begin
				press_start_q <= now_ms;
			end
			if (released_now) begin
				release_q <= now_ms;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/button_click_classifier.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_classifier
// debounced single / double click detector on timestamped button samples
// ----------------------------------------------------------------------------
// channel  | dir | beat contents
// s_*      | in  | tdata[31:0] now_ms, tdata[32] pressed_level
// m_*      | out | tdata[1:0] click_event (0 none, 1 single, 2 double)
// apb      | in  | regs at 0x0 debounce_ms, 0x4 long_press_ms, 0x8 double_gap_ms
//
// one beat per cycle sustained while the output is ready; each beat is held in
// the input register, then the phase machine and the three 32-bit subtract-compares
// produce its event into the output register
// reset clears state and returns registers to 20 / 2000 / 300 ms
// a stalled output holds the pipe; the input register still fills once
// ----------------------------------------------------------------------------
module button_click_classifier
	import bcc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [39:0]      s_tdata,   // now_ms[31:0], pressed_level[32], zero pad
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [7:0]       m_tdata,   // click_event[1:0], zero pad
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [DataW-1:0] pwdata,
	output logic      [DataW-1:0] prdata,
	output logic                  pready
);

	cfg_t              cfg;
	logic              valid_s1;
	logic [TimeW-1:0]  now_s1;
	logic              level_s1;
	logic              advance;
	logic [EventW-1:0] event_d;
	logic [EventW-1:0] event_s2;
	logic              valid_s2;

	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			now_s1   <= s_tdata[TimeW-1:0];
			level_s1 <= s_tdata[TimeW];
		end
		if (advance) begin
			event_s2 <= event_d;
		end
	end

	bcc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bcc_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.now_ms        (now_s1),
		.pressed_level (level_s1),
		.cfg           (cfg),
		.click_event   (event_d)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(8-EventW){1'b0}}, event_s2};

endmodule
`default_nettype wire
